// ===== rtl/xfec_pkg.sv =====
// Shared types and constants for the XOR parity FEC relay with NACK resend.
`timescale 1ns / 1ps

package xfec_pkg;

  localparam int HISTORY_SLOTS_DEF = 128;
  localparam int PAYLOAD_WORDS_DEF = 20;
  localparam int LANES = 8;

  localparam logic [15:0] HOLDOFF_RESET = 16'd100;

  localparam logic [1:0] REQ_WORD = 2'd0;
  localparam logic [1:0] REQ_NACK = 2'd1;
  localparam logic [1:0] REQ_TICK = 2'd2;

  localparam logic [1:0] KIND_DATA   = 2'd0;
  localparam logic [1:0] KIND_PARITY = 2'd1;
  localparam logic [1:0] KIND_RESEND = 2'd2;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [30:0] seq_number;
    logic [4:0]  word_index;
    logic [63:0] payload_word;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  out_kind;
    logic [30:0] out_seq;
    logic [4:0]  out_index;
    logic [63:0] out_word;
    logic        out_last;
  } out_word_t;

  typedef struct packed {
    logic        valid;
    logic        resent;
    logic [30:0] tag;
    logic [31:0] last_time;
  } meta_t;

  typedef struct packed {
    logic pay_we;
    logic pay_re;
    logic par_re;
    logic par_we;
    logic par_hit;
  } lane_ctl_t;

endpackage

// ===== rtl/xfec_slot_mod.sv =====
// Sequence number to history slot reduction (sequence modulo slot count).
`timescale 1ns / 1ps

module xfec_slot_mod #(
  parameter int HISTORY_SLOTS = xfec_pkg::HISTORY_SLOTS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [30:0]                      seq,
  output logic                             done,
  output logic [$clog2(HISTORY_SLOTS)-1:0] slot
);

  localparam int SW = $clog2(HISTORY_SLOTS);
  localparam bit POW2 = (HISTORY_SLOTS & (HISTORY_SLOTS - 1)) == 0;
  localparam int BITS_PER_STEP = 4;
  localparam int STEPS = 32 / BITS_PER_STEP;
  localparam int CW = $clog2(STEPS);

  generate
    if (POW2) begin : g_mask
      logic          done_r;
      logic [SW-1:0] slot_r;

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          done_r <= 1'b0;
        end else begin
          done_r <= start;
        end
        if (start) begin
          slot_r <= seq[SW-1:0];
        end
      end

      assign done = done_r;
      assign slot = slot_r;
    end else begin : g_iter
      localparam logic [SW:0] N_C = (SW + 1)'(HISTORY_SLOTS);

      logic          busy_r;
      logic          done_r;
      logic [CW-1:0] cnt_r;
      logic [31:0]   sh_r;
      logic [SW:0]   rem_r;
      logic [SW:0]   rem_step;

      always_comb begin
        rem_step = rem_r;
        for (int k = 0; k < BITS_PER_STEP; k++) begin
          rem_step = {rem_step[SW-1:0], sh_r[31-k]};
          if (rem_step >= N_C) begin
            rem_step = rem_step - N_C;
          end
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          busy_r <= 1'b0;
          done_r <= 1'b0;
          cnt_r  <= '0;
        end else begin
          done_r <= 1'b0;
          if (start) begin
            busy_r <= 1'b1;
            cnt_r  <= '0;
          end else if (busy_r) begin
            cnt_r <= cnt_r + 1'b1;
            if (cnt_r == CW'(STEPS - 1)) begin
              busy_r <= 1'b0;
              done_r <= 1'b1;
            end
          end
        end
        if (start) begin
          sh_r  <= {1'b0, seq};
          rem_r <= '0;
        end else if (busy_r) begin
          sh_r  <= {sh_r[31-BITS_PER_STEP:0], {BITS_PER_STEP{1'b0}}};
          rem_r <= rem_step;
        end
      end

      assign done = done_r;
      assign slot = rem_r[SW-1:0];
    end
  endgenerate

endmodule

// ===== rtl/xfec_lane.sv =====
// One byte lane: history bytes and the even/odd parity accumulator bytes.
`timescale 1ns / 1ps

module xfec_lane #(
  parameter int HISTORY_SLOTS = xfec_pkg::HISTORY_SLOTS_DEF,
  parameter int PAYLOAD_WORDS = xfec_pkg::PAYLOAD_WORDS_DEF
) (
  input  logic                                            clk,
  input  xfec_pkg::lane_ctl_t                             ctl,
  input  logic [$clog2(HISTORY_SLOTS*PAYLOAD_WORDS)-1:0]  pay_addr,
  input  logic [$clog2(2*PAYLOAD_WORDS)-1:0]              par_addr,
  input  logic [7:0]                                      byte_in,
  output logic [7:0]                                      pay_rd,
  output logic [7:0]                                      par_x
);

  localparam int DEPTH = HISTORY_SLOTS * PAYLOAD_WORDS;
  localparam int PARD  = 2 * PAYLOAD_WORDS;

  logic [7:0] pay_mem [DEPTH];
  logic [7:0] par_mem [PARD];
  logic [7:0] pay_rd_r;
  logic [7:0] par_rd_r;
  logic [7:0] par_x_r;
  logic [7:0] x;

  assign x = (ctl.par_hit ? par_rd_r : 8'h00) ^ byte_in;

  always_ff @(posedge clk) begin
    if (ctl.pay_we) begin
      pay_mem[pay_addr] <= byte_in;
    end
    if (ctl.pay_re) begin
      pay_rd_r <= pay_mem[pay_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.par_re) begin
      par_rd_r <= par_mem[par_addr];
    end
    if (ctl.par_we) begin
      par_mem[par_addr] <= x;
      par_x_r           <= x;
    end
  end

  assign pay_rd = pay_rd_r;
  assign par_x  = par_x_r;

endmodule

// ===== rtl/xor_fec_parity_and_nack_resend_top.sv =====
// Top level of the XOR parity FEC relay with NACK-driven history resend.
//
// Input channel (in_valid/in_ready/in_data) takes one request word: a payload
// word, a NACK or a time tick. Output channel (out_valid/out_ready/out_data)
// gives relayed data, parity and resent words; out_last marks the final word
// caused by one request. cfg_valid/cfg_ready/cfg_data writes holdoff_ticks.
// Eight byte lanes each hold one byte column of the history and of the parity
// accumulators; their bytes are merged into the output word register.
// A payload word passes through the slot reduction (8 steps unless the slot
// count is a power of two), the slot table lookup, the data emit state and,
// when a parity word follows, the parity emit state. The next request is
// taken once the last word of the current one is in the output register. A
// replay gives one resent word a cycle from the lane memory read port while
// the receiver takes them. Ticks, spare request types and payload words with
// an out-of-range index leave the sequencer idle. After reset the slot table
// is cleared slot by slot; in_ready stays low meanwhile, configuration writes
// are taken throughout.
// When the receiver stalls, the output word holds and the sequencer waits.
`timescale 1ns / 1ps

module xor_fec_parity_and_nack_resend_top #(
  parameter int HISTORY_SLOTS = xfec_pkg::HISTORY_SLOTS_DEF,
  parameter int PAYLOAD_WORDS = xfec_pkg::PAYLOAD_WORDS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  xfec_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output xfec_pkg::out_word_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [15:0]         cfg_data
);

  localparam int SW   = $clog2(HISTORY_SLOTS);
  localparam int PAW  = $clog2(HISTORY_SLOTS * PAYLOAD_WORDS);
  localparam int AW   = $clog2(2 * PAYLOAD_WORDS);
  localparam int IW   = (PAYLOAD_WORDS > 1) ? $clog2(PAYLOAD_WORDS) : 1;
  localparam int PARD = 2 * PAYLOAD_WORDS;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_LOOK,
    S_EMIT_DATA,
    S_EMIT_PAR,
    S_REPLAY
  } state_t;

  state_t              state_r;
  xfec_pkg::in_word_t  req_r;
  xfec_pkg::out_word_t out_r;
  logic                out_valid_r;
  logic [SW-1:0]       slot_r;
  logic [SW-1:0]       clr_r;
  logic [PAW-1:0]      base_r;
  logic [AW-1:0]       a_r;
  logic [AW-1:0]       a_nxt;
  logic                par_hit_r;
  logic [PARD-1:0]     par_valid_r;
  logic [IW-1:0]       cnt_r;
  logic [31:0]         tick_r;
  logic [15:0]         holdoff_r;

  logic                in_acc;
  logic                idx_ok;
  logic                mod_start;
  logic                mod_done;
  logic [SW-1:0]       mod_slot;
  logic                out_free;
  logic                out_load;
  logic                is_word;
  logic                rp_last;

  xfec_pkg::meta_t     meta_mem [HISTORY_SLOTS];
  xfec_pkg::meta_t     meta_rd_r;
  xfec_pkg::meta_t     meta_wdata;
  logic                meta_we;
  logic [SW-1:0]       meta_waddr;
  logic                meta_re;
  logic [31:0]         elapsed;
  logic                blocked;
  logic                nack_ok;

  xfec_pkg::lane_ctl_t lane_ctl;
  logic [PAW-1:0]      pay_addr;
  logic [7:0]          lane_pay [xfec_pkg::LANES];
  logic [7:0]          lane_par [xfec_pkg::LANES];
  logic [63:0]         merged_pay;
  logic [63:0]         merged_par;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign idx_ok    = 7'(in_data.word_index) < 7'(PAYLOAD_WORDS);
  assign mod_start = in_acc && ((in_data.req_type == xfec_pkg::REQ_WORD && idx_ok) ||
                                in_data.req_type == xfec_pkg::REQ_NACK);
  assign out_free  = !out_valid_r || out_ready;
  assign out_load  = out_free && (state_r == S_EMIT_DATA || state_r == S_EMIT_PAR ||
                                  state_r == S_REPLAY);
  assign is_word   = (req_r.req_type == xfec_pkg::REQ_WORD);
  assign rp_last   = (cnt_r == IW'(PAYLOAD_WORDS - 1));

  assign a_nxt = in_data.seq_number[0] ? AW'(PAYLOAD_WORDS) + AW'(in_data.word_index)
                                       : AW'(in_data.word_index);

  xfec_slot_mod #(
    .HISTORY_SLOTS(HISTORY_SLOTS)
  ) u_slot_mod (
    .clk  (clk),
    .rst_n(rst_n),
    .start(mod_start),
    .seq  (in_data.seq_number),
    .done (mod_done),
    .slot (mod_slot)
  );

  // Slot table: tag, valid and resend history.
  assign elapsed = tick_r - meta_rd_r.last_time;
  assign blocked = meta_rd_r.resent && (elapsed < {16'h0000, holdoff_r});
  assign nack_ok = meta_rd_r.valid && (meta_rd_r.tag == req_r.seq_number) && !blocked;
  assign meta_re = (state_r == S_MOD) && mod_done;

  always_comb begin
    meta_we    = 1'b0;
    meta_waddr = slot_r;
    meta_wdata = meta_rd_r;
    case (state_r)
      S_CLEAR: begin
        meta_we    = 1'b1;
        meta_waddr = clr_r;
        meta_wdata = '0;
      end
      S_LOOK: begin
        if (is_word) begin
          meta_we          = 1'b1;
          meta_wdata.valid = 1'b1;
          meta_wdata.tag   = req_r.seq_number;
        end else if (nack_ok) begin
          meta_we              = 1'b1;
          meta_wdata.resent    = 1'b1;
          meta_wdata.last_time = tick_r;
        end
      end
      default: begin
        meta_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (meta_we) begin
      meta_mem[meta_waddr] <= meta_wdata;
    end
    if (meta_re) begin
      meta_rd_r <= meta_mem[mod_slot];
    end
  end

  // Lane control.
  always_comb begin
    lane_ctl         = '0;
    lane_ctl.par_hit = par_hit_r;
    pay_addr         = base_r + PAW'(cnt_r) + PAW'(1);
    case (state_r)
      S_MOD: begin
        lane_ctl.par_re = mod_done && is_word;
      end
      S_LOOK: begin
        if (is_word) begin
          lane_ctl.pay_we = 1'b1;
          lane_ctl.par_we = 1'b1;
          pay_addr        = base_r + PAW'(req_r.word_index);
        end else begin
          lane_ctl.pay_re = nack_ok;
          pay_addr        = base_r;
        end
      end
      S_REPLAY: begin
        lane_ctl.pay_re = out_free && !rp_last;
      end
      default: begin
        lane_ctl.pay_re = 1'b0;
      end
    endcase
  end

  generate
    for (genvar g = 0; g < xfec_pkg::LANES; g++) begin : g_lane
      xfec_lane #(
        .HISTORY_SLOTS(HISTORY_SLOTS),
        .PAYLOAD_WORDS(PAYLOAD_WORDS)
      ) u_lane (
        .clk     (clk),
        .ctl     (lane_ctl),
        .pay_addr(pay_addr),
        .par_addr(a_r),
        .byte_in (req_r.payload_word[8*g +: 8]),
        .pay_rd  (lane_pay[g]),
        .par_x   (lane_par[g])
      );
    end
  endgenerate

  // Merge the lane bytes into whole words.
  always_comb begin
    for (int g = 0; g < xfec_pkg::LANES; g++) begin
      merged_pay[8*g +: 8] = lane_pay[g];
      merged_par[8*g +: 8] = lane_par[g];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      par_valid_r <= '0;
      tick_r      <= '0;
      holdoff_r   <= xfec_pkg::HOLDOFF_RESET;
      cnt_r       <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        holdoff_r <= cfg_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == SW'(HISTORY_SLOTS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            req_r <= in_data;
            a_r   <= a_nxt;
            if (in_data.req_type == xfec_pkg::REQ_TICK) begin
              tick_r <= tick_r + 32'd1;
            end
            if (mod_start) begin
              state_r <= S_MOD;
            end
          end
        end
        S_MOD: begin
          if (mod_done) begin
            slot_r    <= mod_slot;
            base_r    <= PAW'(PAW'(mod_slot) * PAW'(PAYLOAD_WORDS));
            par_hit_r <= par_valid_r[a_r];
            state_r   <= S_LOOK;
          end
        end
        S_LOOK: begin
          cnt_r <= '0;
          if (is_word) begin
            par_valid_r[a_r] <= !req_r.seq_number[1];
            state_r          <= S_EMIT_DATA;
          end else if (nack_ok) begin
            state_r <= S_REPLAY;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_EMIT_DATA: begin
          if (out_free) begin
            out_r.out_kind  <= xfec_pkg::KIND_DATA;
            out_r.out_seq   <= req_r.seq_number;
            out_r.out_index <= req_r.word_index;
            out_r.out_word  <= req_r.payload_word;
            out_r.out_last  <= !req_r.seq_number[1];
            state_r         <= req_r.seq_number[1] ? S_EMIT_PAR : S_IDLE;
          end
        end
        S_EMIT_PAR: begin
          if (out_free) begin
            out_r.out_kind  <= xfec_pkg::KIND_PARITY;
            out_r.out_seq   <= req_r.seq_number;
            out_r.out_index <= req_r.word_index;
            out_r.out_word  <= merged_par;
            out_r.out_last  <= 1'b1;
            state_r         <= S_IDLE;
          end
        end
        S_REPLAY: begin
          if (out_free) begin
            out_r.out_kind  <= xfec_pkg::KIND_RESEND;
            out_r.out_seq   <= req_r.seq_number;
            out_r.out_index <= 5'(cnt_r);
            out_r.out_word  <= merged_pay;
            out_r.out_last  <= rp_last;
            if (rp_last) begin
              state_r <= S_IDLE;
            end else begin
              cnt_r <= cnt_r + 1'b1;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_mod_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    mod_done |-> (state_r == S_MOD))
    else $error("slot reduction finished outside its wait state");

  a_replay_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_REPLAY) |-> (32'(cnt_r) < PAYLOAD_WORDS))
    else $error("replay counter beyond the packet length");

  a_parity_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.out_kind == xfec_pkg::KIND_PARITY) |-> out_r.out_last)
    else $error("parity word not marked last");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_REPLAY || state_r == S_LOOK) |=> !$rose(mod_done))
    else $error("slot reduction restarted while a request is in flight");

endmodule

// ===== test/xfec_relay_checker.sv =====
// Checker for the FEC relay: predicts relayed, parity and resent words and compares them.
`timescale 1ns / 1ps

module xfec_relay_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  xfec_pkg::in_word_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  xfec_pkg::out_word_t out_data,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [15:0]         cfg_data,
  output int                  fail_count,
  output int                  pending
);

  localparam int SLOTS = xfec_pkg::HISTORY_SLOTS_DEF;
  localparam int PW    = xfec_pkg::PAYLOAD_WORDS_DEF;

  logic [63:0]         hist_words [SLOTS*PW];
  logic [30:0]         hist_tag [SLOTS];
  bit                  hist_valid [SLOTS];
  logic [31:0]         resend_at [SLOTS];
  bit                  resend_done [SLOTS];
  logic [63:0]         parity_sum [2*PW];
  logic [31:0]         tick_now;
  logic [15:0]         holdoff;
  xfec_pkg::out_word_t due_words [$];
  int                  misses;

  initial begin
    fail_count = 0;
    pending = 0;
    misses = 0;
  end

  function automatic xfec_pkg::out_word_t make_word(logic [1:0] kind, logic [30:0] seq,
                                                    logic [4:0] idx, logic [63:0] data,
                                                    logic last);
    xfec_pkg::out_word_t r;
    r.out_kind  = kind;
    r.out_seq   = seq;
    r.out_index = idx;
    r.out_word  = data;
    r.out_last  = last;
    return r;
  endfunction

  task automatic compute_relay_words(input xfec_pkg::in_word_t rq);
    int          slot;
    int          acc;
    logic [31:0] gap;
    slot = rq.seq_number % SLOTS;
    case (rq.req_type)
      xfec_pkg::REQ_WORD: begin
        if (rq.word_index < PW) begin
          hist_words[slot*PW + rq.word_index] = rq.payload_word;
          hist_tag[slot] = rq.seq_number;
          hist_valid[slot] = 1'b1;
          acc = rq.seq_number[0] ? PW + rq.word_index : rq.word_index;
          parity_sum[acc] ^= rq.payload_word;
          due_words.push_back(make_word(xfec_pkg::KIND_DATA, rq.seq_number,
                                        rq.word_index, rq.payload_word,
                                        !rq.seq_number[1]));
          if (rq.seq_number[1]) begin
            due_words.push_back(make_word(xfec_pkg::KIND_PARITY, rq.seq_number,
                                          rq.word_index, parity_sum[acc], 1'b1));
            parity_sum[acc] = '0;
          end
        end
      end
      xfec_pkg::REQ_NACK: begin
        gap = tick_now - resend_at[slot];
        if (hist_valid[slot] && hist_tag[slot] == rq.seq_number &&
            !(resend_done[slot] && gap < {16'd0, holdoff})) begin
          for (int i = 0; i < PW; i++)
            due_words.push_back(make_word(xfec_pkg::KIND_RESEND, rq.seq_number, 5'(i),
                                          hist_words[slot*PW + i], i == PW - 1));
          resend_at[slot] = tick_now;
          resend_done[slot] = 1'b1;
        end
      end
      xfec_pkg::REQ_TICK: tick_now = tick_now + 32'd1;
      default: ;
    endcase
  endtask

  always @(posedge clk) begin : watch
    xfec_pkg::out_word_t exp;
    if (!rst_n) begin
      for (int s = 0; s < SLOTS; s++) begin
        hist_valid[s] = 1'b0;
        resend_done[s] = 1'b0;
      end
      for (int a = 0; a < 2*PW; a++)
        parity_sum[a] = '0;
      tick_now = '0;
      holdoff = xfec_pkg::HOLDOFF_RESET;
      due_words.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (due_words.size() == 0) begin
          if (misses < 10)
            $display("unexpected word: kind %0d seq %h index %0d word %h last %b",
                     out_data.out_kind, out_data.out_seq, out_data.out_index,
                     out_data.out_word, out_data.out_last);
          misses++;
        end else begin
          exp = due_words.pop_front();
          if (out_data.out_kind !== exp.out_kind || out_data.out_seq !== exp.out_seq ||
              out_data.out_index !== exp.out_index || out_data.out_word !== exp.out_word ||
              out_data.out_last !== exp.out_last) begin
            if (misses < 10)
              $display({"mismatch: expected kind %0d seq %h index %0d word %h last %b, ",
                        "got kind %0d seq %h index %0d word %h last %b"},
                       exp.out_kind, exp.out_seq, exp.out_index, exp.out_word, exp.out_last,
                       out_data.out_kind, out_data.out_seq, out_data.out_index,
                       out_data.out_word, out_data.out_last);
            misses++;
          end
        end
      end
      if (cfg_valid && cfg_ready)
        holdoff = cfg_data;
      if (in_valid && in_ready)
        compute_relay_words(in_data);
    end
    fail_count <= misses;
    pending <= due_words.size();
  end

endmodule

// ===== test/xor_fec_parity_and_nack_resend_top_tb.sv =====
// Testbench top for the FEC relay: drives requests, holdoff writes and output stalls.
`timescale 1ns / 1ps

module xor_fec_parity_and_nack_resend_top_tb;

  localparam int SLOTS       = xfec_pkg::HISTORY_SLOTS_DEF;
  localparam int PW          = xfec_pkg::PAYLOAD_WORDS_DEF;
  localparam int POOL        = 6;
  localparam int CYCLE_LIMIT = 300000;
  localparam int SETTLE      = 2*PW + 8;
  localparam int LONG_HOLD   = 300;
  localparam int QUOTA       = 45;
  localparam logic [1:0] REQ_SPARE = 2'd3;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  xfec_pkg::in_word_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  xfec_pkg::out_word_t out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [15:0]         cfg_data = '0;
  int                  fail_count;
  int                  pending;

  int send_idle = 38;
  int recv_idle = 72;
  int phase = 0;
  int hold_phase = 0;
  int hold_left = 0;
  int items_sent = 0;
  int cycle_count = 0;

  bit            seen [SLOTS];
  logic [30:0]   last_tag [SLOTS];
  logic [PW-1:0] filled [SLOTS];
  int            slot_pool [POOL];

  xor_fec_parity_and_nack_resend_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  xfec_relay_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (phase != hold_phase) begin
      hold_phase = phase;
      if (phase == 2 || phase == 3)
        hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  function automatic xfec_pkg::in_word_t mk_req(logic [1:0] t, logic [30:0] s,
                                                logic [4:0] idx, logic [63:0] data);
    xfec_pkg::in_word_t w;
    w.req_type     = t;
    w.seq_number   = s;
    w.word_index   = idx;
    w.payload_word = data;
    return w;
  endfunction

  function automatic logic [30:0] seq_in_slot(int slot);
    logic [30:0] s;
    s = 31'($urandom());
    return s - 31'(s % SLOTS) + 31'(slot);
  endfunction

  function automatic bit nack_safe(logic [30:0] s);
    int slot;
    slot = s % SLOTS;
    return !(seen[slot] && last_tag[slot] == s && !(&filled[slot]));
  endfunction

  function automatic logic [63:0] pick_payload();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  task automatic idle_sender();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic issue(input xfec_pkg::in_word_t w);
    int slot;
    slot = w.seq_number % SLOTS;
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (w.req_type == xfec_pkg::REQ_WORD && w.word_index < PW) begin
      seen[slot] = 1'b1;
      last_tag[slot] = w.seq_number;
      filled[slot][w.word_index] = 1'b1;
      items_sent++;
    end else if (w.req_type == xfec_pkg::REQ_NACK || w.req_type == xfec_pkg::REQ_TICK) begin
      items_sent++;
    end
  endtask

  task automatic settle_all();
    idle_sender();
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_holdoff(input logic [15:0] v);
    settle_all();
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_packet(input logic [30:0] s, input bit shuffle);
    int order [PW];
    int j;
    int tmp;
    for (int i = 0; i < PW; i++)
      order[i] = i;
    if (shuffle) begin
      for (int i = PW - 1; i > 0; i--) begin
        j = $urandom_range(0, i);
        tmp = order[i];
        order[i] = order[j];
        order[j] = tmp;
      end
    end
    for (int i = 0; i < PW; i++)
      issue(mk_req(xfec_pkg::REQ_WORD, s, 5'(order[i]), pick_payload()));
  endtask

  task automatic run_phase(input int quota, input logic [15:0] holdoff, input int s_idle,
                           input int r_idle, input int ph);
    int          start_count;
    int          pick;
    int          slot;
    int          n;
    bit          paused;
    logic [30:0] s;
    write_holdoff(holdoff);
    @(posedge clk);
    send_idle = s_idle;
    recv_idle = r_idle;
    phase = ph;
    start_count = items_sent;
    paused = 1'b0;
    while (items_sent - start_count < quota) begin
      if (!paused && items_sent - start_count >= quota / 2) begin
        paused = 1'b1;
        settle_all();
      end
      pick = $urandom_range(0, 99);
      slot = slot_pool[$urandom_range(0, POOL - 1)];
      if (pick < 45) begin
        if (seen[slot] && $urandom_range(0, 3) == 0)
          s = last_tag[slot];
        else
          s = seq_in_slot(slot);
        send_packet(s, $urandom_range(0, 2) == 0);
      end else if (pick < 70) begin
        s = seen[slot] ? last_tag[slot] : seq_in_slot(slot);
        if (nack_safe(s))
          issue(mk_req(xfec_pkg::REQ_NACK, s, 5'($urandom()), {$urandom(), $urandom()}));
      end else if (pick < 82) begin
        n = $urandom_range(1, 6);
        repeat (n)
          issue(mk_req(xfec_pkg::REQ_TICK, 31'($urandom()), 5'($urandom()),
                       {$urandom(), $urandom()}));
      end else if (pick < 88) begin
        s = seq_in_slot(slot);
        n = $urandom_range(1, 5);
        repeat (n)
          issue(mk_req(xfec_pkg::REQ_WORD, s, 5'($urandom_range(0, PW - 1)),
                       pick_payload()));
      end else begin
        case ($urandom_range(0, 2))
          0: begin
            s = 31'($urandom());
            if (nack_safe(s))
              issue(mk_req(xfec_pkg::REQ_NACK, s, 5'($urandom()),
                           {$urandom(), $urandom()}));
          end
          1: issue(mk_req(REQ_SPARE, 31'($urandom()), 5'($urandom()),
                          {$urandom(), $urandom()}));
          default: issue(mk_req(xfec_pkg::REQ_WORD, 31'($urandom()),
                                5'($urandom_range(PW, 31)), pick_payload()));
        endcase
      end
    end
  endtask

  initial begin : stimulus
    logic [30:0] top_seq;
    logic [63:0] data;
    for (int i = 0; i < SLOTS; i++) begin
      seen[i] = 1'b0;
      filled[i] = '0;
      last_tag[i] = '0;
    end
    top_seq = 31'h7FFF_FFFE;
    slot_pool[0] = top_seq % SLOTS;
    for (int i = 1; i < POOL; i++)
      slot_pool[i] = $urandom_range(0, SLOTS - 1);
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < PW; i++) begin
      case (i)
        0: data = '0;
        1: data = '1;
        2: data = {16{4'hA}};
        3: data = {16{4'h5}};
        default: data = {$urandom(), $urandom()};
      endcase
      issue(mk_req(xfec_pkg::REQ_WORD, top_seq, 5'(i), data));
    end
    issue(mk_req(xfec_pkg::REQ_NACK, top_seq, 5'd31, '1));
    issue(mk_req(xfec_pkg::REQ_NACK, top_seq, 5'd0, '0));
    issue(mk_req(xfec_pkg::REQ_NACK, 31'h7FFF_FF7E, 5'd0, '0));
    issue(mk_req(xfec_pkg::REQ_NACK, 31'd5, 5'd0, '0));
    issue(mk_req(xfec_pkg::REQ_TICK, '1, '1, '1));
    issue(mk_req(REQ_SPARE, top_seq, 5'd3, '1));
    issue(mk_req(xfec_pkg::REQ_WORD, top_seq, 5'(PW), '1));
    issue(mk_req(xfec_pkg::REQ_WORD, 31'd0, 5'd31, '1));

    run_phase(QUOTA, 16'd0, 38, 72, 1);
    run_phase(QUOTA, 16'hFFFF, 72, 38, 2);
    run_phase(QUOTA, 16'd3, 0, 0, 3);
    run_phase(QUOTA, 16'($urandom_range(1, 40)), 0, 0, 4);

    settle_all();
    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/xfec_pkg.sv
rtl/xfec_slot_mod.sv
rtl/xfec_lane.sv
rtl/xor_fec_parity_and_nack_resend_top.sv
test/xfec_relay_checker.sv
test/xor_fec_parity_and_nack_resend_top_tb.sv
